FILE: rtl/core/ioq_pkg.sv
// Shared types, constants and register codes of the impact-ordered task queue.
package ioq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TASK_W    = 8;
    localparam int COH_W     = 32;
    localparam int SCORE_W   = 34;
    localparam int BOOST_W   = 17;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONS_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONS_BOOST = 2'd2;

    localparam logic [COH_W-1:0]   ALIGN_THR_RST  = 32'h0000_8000;
    localparam logic [COH_W-1:0]   CONS_THR_RST   = 32'h0000_C000;
    localparam logic [BOOST_W-1:0] CONS_BOOST_RST = 17'h1_0000;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic               sub;
        logic [SCORE_W-1:0] a;
        logic [SCORE_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [SCORE_W-1:0] score;
    } t_slot;

endpackage

FILE: rtl/core/ioq_if.sv
// Valid/ready channel interfaces for the task queue input and result words.
interface ioq_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [ioq_pkg::TASK_W-1:0] task_id;
    logic [ioq_pkg::COH_W-1:0]  current_coherence;
    logic [ioq_pkg::COH_W-1:0]  target_coherence;
    logic [ioq_pkg::COH_W-1:0]  align_metric;
    logic [ioq_pkg::COH_W-1:0]  consist_metric;

    modport source (
        output valid, mode, task_id, current_coherence, target_coherence,
               align_metric, consist_metric,
        input  ready
    );
    modport sink (
        input  valid, mode, task_id, current_coherence, target_coherence,
               align_metric, consist_metric,
        output ready
    );
endinterface

interface ioq_out_if;
    logic                         valid;
    logic                         ready;
    logic [ioq_pkg::STATUS_W-1:0] status;
    logic [ioq_pkg::SCORE_W-1:0]  item_score;
    logic                         head_valid;
    logic [ioq_pkg::TASK_W-1:0]   head_task;
    logic [ioq_pkg::SCORE_W-1:0]  head_score;
    logic [ioq_pkg::OCC_W-1:0]    occupancy;

    modport source (
        output valid, status, item_score, head_valid, head_task, head_score, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, item_score, head_valid, head_task, head_score, occupancy,
        output ready
    );
endinterface

FILE: rtl/core/ioq_alu.sv
// Shared 34-bit add/subtract unit with borrow out, used for scoring and compares.
module ioq_alu (
    input  ioq_pkg::t_alu_req             i_req,
    output logic [ioq_pkg::SCORE_W-1:0]   o_res,
    output logic                          o_borrow
);

    logic [ioq_pkg::SCORE_W:0]   w_sum;
    logic [ioq_pkg::SCORE_W-1:0] w_b;

    assign w_b      = i_req.sub ? ~i_req.b : i_req.b;
    assign w_sum    = {1'b0, i_req.a} + {1'b0, w_b} + {{ioq_pkg::SCORE_W{1'b0}}, i_req.sub};
    assign o_res    = w_sum[ioq_pkg::SCORE_W-1:0];
    assign o_borrow = i_req.sub & ~w_sum[ioq_pkg::SCORE_W];

endmodule

FILE: rtl/core/ioq_store.sv
// Queue slot memory: one write port, one registered read port.
module ioq_store #(
    parameter int QUEUE_DEPTH = ioq_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  ioq_pkg::t_slot    i_wdata,
    input  logic [IDX_W-1:0]  i_raddr,
    output ioq_pkg::t_slot    o_rdata
);

    ioq_pkg::t_slot r_mem [QUEUE_DEPTH];
    ioq_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/impact_ordered_task_queue_unit.sv
// Top level of the impact-ordered task queue: sequencer, configuration and result register.
//
// A run queue of up to QUEUE_DEPTH task ids kept in descending urgency score, earlier
// arrival first among equal scores. Each input word (enqueue with coherence metrics, or
// dequeue by id) yields one result word with status, the computed score, the head task
// and the occupancy after the word. The block takes one word at a time and is not ready
// while it works on it. An enqueue forms the score, then walks the queue from the tail,
// moving each lower-scored task down a slot until the new task is placed (a full queue
// skips the walk); a dequeue reads from the head until the id is found or the end is
// reached, then moves each later task up a slot. The time taken is set by the single
// read port of the slot memory, which is walked one entry at a time, and by the one
// shared subtractor that forms the score in four steps and does every score compare.
// A finished result waits in the output register, and the next word is taken meanwhile;
// its last step holds while the output register still carries an unaccepted word.
// Configuration writes take effect at once and belong between words; a write to an
// unused index is ignored.
module impact_ordered_task_queue_unit #(
    parameter int QUEUE_DEPTH = ioq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ioq_in_if.sink                          i_in,
    ioq_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [ioq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ioq_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_ALIGN,
        S_CONS,
        S_BOOST,
        S_INS_RD,
        S_INS_CMP,
        S_DQ_RD,
        S_DQ_CMP,
        S_SH_RD,
        S_SH_WR,
        S_HEAD,
        S_FIN
    } t_state;

    t_state                          r_state;
    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                r_idx;

    logic [ioq_pkg::COH_W-1:0]       r_align_thr;
    logic [ioq_pkg::COH_W-1:0]       r_cons_thr;
    logic [ioq_pkg::BOOST_W-1:0]     r_cons_boost;

    logic [ioq_pkg::TASK_W-1:0]      r_id;
    logic [ioq_pkg::COH_W-1:0]       r_cur;
    logic [ioq_pkg::COH_W-1:0]       r_tgt;
    logic [ioq_pkg::COH_W-1:0]       r_align;
    logic [ioq_pkg::COH_W-1:0]       r_cons;

    logic [ioq_pkg::SCORE_W-1:0]     r_drift;
    logic                            r_zero;
    logic                            r_dbl;
    logic                            r_add;
    logic [ioq_pkg::SCORE_W-1:0]     r_score;
    ioq_pkg::t_status                r_status;

    logic                            r_out_valid;
    ioq_pkg::t_status                r_o_status;
    logic [ioq_pkg::SCORE_W-1:0]     r_o_item;
    logic                            r_o_head_valid;
    logic [ioq_pkg::TASK_W-1:0]      r_o_head_task;
    logic [ioq_pkg::SCORE_W-1:0]     r_o_head_score;
    logic [ioq_pkg::OCC_W-1:0]       r_o_occ;

    ioq_pkg::t_alu_req               w_alu_req;
    logic [ioq_pkg::SCORE_W-1:0]     w_alu_res;
    logic                            w_alu_borrow;

    logic                            w_we;
    logic [IDX_W-1:0]                w_waddr;
    ioq_pkg::t_slot                  w_wdata;
    logic [IDX_W-1:0]                w_raddr;
    ioq_pkg::t_slot                  w_rdata;
    ioq_pkg::t_slot                  w_new;

    logic [CNT_W-1:0]                w_idx_dec;
    logic [CNT_W-1:0]                w_idx_inc;
    logic [CNT_W+ioq_pkg::OCC_W-1:0] w_occ_ext;
    logic                            w_full;
    logic                            w_nonempty;

    assign w_idx_dec  = r_idx - CNT_W'(1);
    assign w_idx_inc  = r_idx + CNT_W'(1);
    assign w_occ_ext  = {{ioq_pkg::OCC_W{1'b0}}, r_count};
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_nonempty = (r_count != '0);
    assign w_new      = '{task_id: r_id, score: r_score};

    ioq_alu u_alu (
        .i_req    (w_alu_req),
        .o_res    (w_alu_res),
        .o_borrow (w_alu_borrow)
    );

    ioq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_alu_req = '0;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = w_rdata;
        w_raddr   = '0;
        case (r_state)
            S_DIFF: begin
                w_alu_req.sub = 1'b1;
                w_alu_req.a   = {2'b00, r_tgt};
                w_alu_req.b   = {2'b00, r_cur};
            end
            S_ALIGN: begin
                w_alu_req.sub = 1'b1;
                w_alu_req.a   = {2'b00, r_align};
                w_alu_req.b   = {2'b00, r_align_thr};
            end
            S_CONS: begin
                w_alu_req.sub = 1'b1;
                w_alu_req.a   = {2'b00, r_cons};
                w_alu_req.b   = {2'b00, r_cons_thr};
            end
            S_BOOST: begin
                w_alu_req.sub = 1'b0;
                w_alu_req.a   = r_dbl ? {r_drift[ioq_pkg::SCORE_W-2:0], 1'b0} : r_drift;
                w_alu_req.b   = r_add ? {{(ioq_pkg::SCORE_W - ioq_pkg::BOOST_W){1'b0}},
                                         r_cons_boost} : '0;
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = w_new;
                end else begin
                    w_raddr = w_idx_dec[IDX_W-1:0];
                end
            end
            S_INS_CMP: begin
                w_alu_req.sub = 1'b1;
                w_alu_req.a   = w_rdata.score;
                w_alu_req.b   = r_score;
                w_we          = 1'b1;
                w_waddr       = r_idx[IDX_W-1:0];
                w_wdata       = w_alu_borrow ? w_rdata : w_new;
            end
            S_DQ_RD: begin
                w_raddr = r_idx[IDX_W-1:0];
            end
            S_SH_RD: begin
                w_raddr = w_idx_inc[IDX_W-1:0];
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IDX_W-1:0];
                w_wdata = w_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_align_thr  <= ioq_pkg::ALIGN_THR_RST;
            r_cons_thr   <= ioq_pkg::CONS_THR_RST;
            r_cons_boost <= ioq_pkg::CONS_BOOST_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ioq_pkg::CFG_ALIGN_THR:  r_align_thr  <= i_cfg_data;
                    ioq_pkg::CFG_CONS_THR:   r_cons_thr   <= i_cfg_data;
                    ioq_pkg::CFG_CONS_BOOST: r_cons_boost <= i_cfg_data[ioq_pkg::BOOST_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_id     <= i_in.task_id;
                        r_cur    <= i_in.current_coherence;
                        r_tgt    <= i_in.target_coherence;
                        r_align  <= i_in.align_metric;
                        r_cons   <= i_in.consist_metric;
                        r_score  <= '0;
                        r_status <= ioq_pkg::ST_OK;
                        r_idx    <= '0;
                        r_state  <= (i_in.mode == ioq_pkg::MODE_DEQ) ? S_DQ_RD : S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_drift <= w_alu_res;
                    r_zero  <= w_alu_borrow | (w_alu_res == '0);
                    r_state <= S_ALIGN;
                end
                S_ALIGN: begin
                    r_dbl   <= w_alu_borrow;
                    r_state <= S_CONS;
                end
                S_CONS: begin
                    r_add   <= w_alu_borrow;
                    r_state <= S_BOOST;
                end
                S_BOOST: begin
                    r_score <= r_zero ? '0 : w_alu_res;
                    if (w_full) begin
                        r_status <= ioq_pkg::ST_FULL;
                        r_state  <= S_HEAD;
                    end else begin
                        r_idx   <= r_count;
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_RD: begin
                    if (r_idx == '0) begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_HEAD;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (w_alu_borrow) begin
                        r_idx   <= w_idx_dec;
                        r_state <= S_INS_RD;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_HEAD;
                    end
                end
                S_DQ_RD: begin
                    if (r_idx == r_count) begin
                        r_status <= ioq_pkg::ST_NOT_FOUND;
                        r_state  <= S_HEAD;
                    end else begin
                        r_state <= S_DQ_CMP;
                    end
                end
                S_DQ_CMP: begin
                    if (w_rdata.task_id == r_id) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_idx   <= w_idx_inc;
                        r_state <= S_DQ_RD;
                    end
                end
                S_SH_RD: begin
                    if (w_idx_inc == r_count) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_HEAD;
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_idx   <= w_idx_inc;
                    r_state <= S_SH_RD;
                end
                S_HEAD: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid    <= 1'b1;
                        r_o_status     <= r_status;
                        r_o_item       <= r_score;
                        r_o_head_valid <= w_nonempty;
                        r_o_head_task  <= w_nonempty ? w_rdata.task_id : '0;
                        r_o_head_score <= w_nonempty ? w_rdata.score : '0;
                        r_o_occ        <= w_occ_ext[ioq_pkg::OCC_W-1:0];
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_o_status;
    assign o_out.item_score = r_o_item;
    assign o_out.head_valid = r_o_head_valid;
    assign o_out.head_task  = r_o_head_task;
    assign o_out.head_score = r_o_head_score;
    assign o_out.occupancy  = r_o_occ;

endmodule

FILE: rtl/core/ioq_check.sv
// Port-level assertions for the task queue top level, with the bind that attaches them.
module ioq_check #(
    parameter int QUEUE_DEPTH = ioq_pkg::QUEUE_DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ioq_pkg::STATUS_W-1:0]  i_status,
    input logic [ioq_pkg::SCORE_W-1:0]   i_item_score,
    input logic                          i_head_valid,
    input logic [ioq_pkg::TASK_W-1:0]    i_head_task,
    input logic [ioq_pkg::SCORE_W-1:0]   i_head_score,
    input logic [ioq_pkg::OCC_W-1:0]     i_occupancy
);

    localparam logic SMALL_Q = (QUEUE_DEPTH < 32);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_item_score) && $stable(i_head_task) && $stable(i_occupancy))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after accept");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_head_valid |-> i_head_task == '0 && i_head_score == '0)
        else $error("empty queue reports a head");

    a_occ_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && SMALL_Q |-> (i_head_valid == (i_occupancy != '0))
            && (i_status != ioq_pkg::ST_FULL
                || i_occupancy == ioq_pkg::OCC_W'(QUEUE_DEPTH)))
        else $error("occupancy disagrees with head or full status");

endmodule

bind impact_ordered_task_queue_unit ioq_check #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ioq_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_item_score (o_out.item_score),
    .i_head_valid (o_out.head_valid),
    .i_head_task  (o_out.head_task),
    .i_head_score (o_out.head_score),
    .i_occupancy  (o_out.occupancy)
);
